// ===== src/lr2x_pkg.sv =====
// Shared constants, codes and types of the two-band crossover filter.
// Used by lr2_crossover_filter; depends on nothing else.
`timescale 1ns / 1ps

package lr2x_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int COEF_FRAC_BITS  = 22;
	localparam int STATE_FRAC_BITS = 8;
	localparam int STATE_BITS      = 40;
	localparam int INNER_BITS      = 38;
	localparam int COEF_BITS       = 25;
	localparam int NUM_REGS        = 8;
	localparam int REG_IDX_BITS    = $clog2(NUM_REGS);

	localparam int SHIFT      = COEF_FRAC_BITS - STATE_FRAC_BITS;
	localparam int YLO_BITS   = INNER_BITS / 2;
	localparam int YHI_BITS   = INNER_BITS - YLO_BITS;
	localparam int MUL_B_BITS = (SAMPLE_BITS > YHI_BITS + 1) ? SAMPLE_BITS : YHI_BITS + 1;
	localparam int PROD_BITS  = COEF_BITS + MUL_B_BITS;
	localparam int FULL_BITS  = COEF_BITS + INNER_BITS + 1;
	localparam int RND_BITS   = FULL_BITS - SHIFT;
	localparam int SUM_BITS   = RND_BITS + 2;
	localparam int OUT_PRE_BITS = (INNER_BITS - STATE_FRAC_BITS + 1 > SAMPLE_BITS + 1) ?
		INNER_BITS - STATE_FRAC_BITS + 1 : SAMPLE_BITS + 1;
	localparam int YR_BITS    = OUT_PRE_BITS + STATE_FRAC_BITS;

	localparam logic signed [FULL_BITS-1:0] RND_HALF = FULL_BITS'(1) << (SHIFT - 1);
	localparam logic signed [YR_BITS-1:0]   OUT_HALF = YR_BITS'(1) << (STATE_FRAC_BITS - 1);

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_LP_FF0 = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_LP_FF1 = REG_IDX_BITS'(1);
	localparam logic [REG_IDX_BITS-1:0] REG_LP_FF2 = REG_IDX_BITS'(2);
	localparam logic [REG_IDX_BITS-1:0] REG_HP_FF0 = REG_IDX_BITS'(3);
	localparam logic [REG_IDX_BITS-1:0] REG_HP_FF1 = REG_IDX_BITS'(4);
	localparam logic [REG_IDX_BITS-1:0] REG_HP_FF2 = REG_IDX_BITS'(5);
	localparam logic [REG_IDX_BITS-1:0] REG_FB1    = REG_IDX_BITS'(6);
	localparam logic [REG_IDX_BITS-1:0] REG_FB2    = REG_IDX_BITS'(7);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_FF0,
		OP_FF1,
		OP_FF2,
		OP_FB1_LO,
		OP_FB1_HI,
		OP_FB2_LO,
		OP_FB2_HI
	} op_t;

endpackage

// ===== src/lr2_crossover_filter.sv =====
// Two-band crossover: low-pass and high-pass biquads on one shared multiplier.
// Depends on lr2x_pkg.
`timescale 1ns / 1ps

// Each transferred sample goes from input transfer to a result ready in
// the output register as follows: the seven products of each band
// (three feedforward, two feedback split into low and high halves of the
// 38-bit band value) pass one after another through a single registered
// 25 x 24 signed multiplier, and a fresh sample is taken once the previous
// one has left the arithmetic, so no sample is taken while one is in work.
// A finished result waits in the output register, so the next sample may
// be taken before it is collected; a result still waiting when the next
// one finishes holds that one until the first is collected.
// Any coefficient write clears the four section states; write only while
// idle.
module lr2_crossover_filter
	import lr2x_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [REG_IDX_BITS-1:0]        cfg_index,
	input  logic signed [COEF_BITS-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_BITS-1:0]  sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_BITS-1:0]  low_band,
	output logic signed [SAMPLE_BITS-1:0]  high_band,
	output logic                           clipped
);

	function automatic logic signed [INNER_BITS-1:0] sat_inner(
		input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-INNER_BITS:0] top;
		top = v[SUM_BITS-1:INNER_BITS-1];
		if ((&top) || !(|top))
			return v[INNER_BITS-1:0];
		return v[SUM_BITS-1] ? {1'b1, {(INNER_BITS-1){1'b0}}} : {1'b0, {(INNER_BITS-1){1'b1}}};
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-STATE_BITS:0] top;
		top = v[SUM_BITS-1:STATE_BITS-1];
		if ((&top) || !(|top))
			return v[STATE_BITS-1:0];
		return v[SUM_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
	endfunction

	state_t state_q, state_d;
	logic   finish;

	logic signed [COEF_BITS-1:0]   coef_q [NUM_REGS];
	logic signed [STATE_BITS-1:0]  st_a_q [2];
	logic signed [STATE_BITS-1:0]  st_b_q [2];
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [INNER_BITS-1:0]  y_q;
	logic signed [SUM_BITS-1:0]    ta_q, tb_q;
	logic signed [FULL_BITS-1:0]   acc_q;
	logic signed [SAMPLE_BITS-1:0] lo_q, hi_q;
	logic                          clip_q;

	logic                          iss_on_q;
	logic                          iss_sec_q;
	op_t                           iss_op_q;
	logic                          mvld_s1;
	logic                          msec_s1;
	op_t                           mop_s1;
	logic signed [PROD_BITS-1:0]   prod_s1;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] low_band_q, high_band_q;
	logic                          clipped_q;

	logic [REG_IDX_BITS-1:0]       coef_sel;
	logic signed [COEF_BITS-1:0]   mul_a;
	logic signed [MUL_B_BITS-1:0]  mul_b;
	logic signed [PROD_BITS-1:0]   mul_p;

	logic signed [FULL_BITS-1:0]   full;
	logic signed [FULL_BITS-1:0]   rnd_w;
	logic signed [RND_BITS-1:0]    rnd;
	logic signed [SUM_BITS-1:0]    rnd_x;
	logic signed [SUM_BITS-1:0]    sum;

	logic signed [YR_BITS-1:0]      y_r;
	logic signed [OUT_PRE_BITS-1:0] o_pre;
	logic [OUT_PRE_BITS-SAMPLE_BITS:0] o_top;
	logic signed [SAMPLE_BITS-1:0]  band;
	logic                           band_clip;

	logic accept;

	assign accept = in_valid && in_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (mvld_s1 && msec_s1 && mop_s1 == OP_FB2_HI)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// multiplier operand selection
	always_comb begin
		unique case (iss_op_q)
			OP_FF0:               coef_sel = iss_sec_q ? REG_HP_FF0 : REG_LP_FF0;
			OP_FF1:               coef_sel = iss_sec_q ? REG_HP_FF1 : REG_LP_FF1;
			OP_FF2:               coef_sel = iss_sec_q ? REG_HP_FF2 : REG_LP_FF2;
			OP_FB1_LO, OP_FB1_HI: coef_sel = REG_FB1;
			default:              coef_sel = REG_FB2;
		endcase
		mul_a = coef_q[coef_sel];
		case (iss_op_q)
			OP_FB1_LO, OP_FB2_LO: mul_b = MUL_B_BITS'({1'b0, y_q[YLO_BITS-1:0]});
			OP_FB1_HI, OP_FB2_HI: mul_b = MUL_B_BITS'($signed(y_q[INNER_BITS-1:YLO_BITS]));
			default:              mul_b = MUL_B_BITS'(x_q);
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// product rounding and accumulation
	always_comb begin
		if (mop_s1 == OP_FB1_HI || mop_s1 == OP_FB2_HI)
			full = (FULL_BITS'(prod_s1) <<< YLO_BITS) + acc_q;
		else
			full = FULL_BITS'(prod_s1);
		rnd_w = full + RND_HALF;
		rnd   = rnd_w[FULL_BITS-1:SHIFT];
		rnd_x = SUM_BITS'(rnd);
		case (mop_s1)
			OP_FF0:    sum = rnd_x + SUM_BITS'(st_a_q[msec_s1]);
			OP_FF1:    sum = rnd_x + SUM_BITS'(st_b_q[msec_s1]);
			OP_FB1_HI: sum = ta_q - rnd_x;
			OP_FB2_HI: sum = tb_q - rnd_x;
			default:   sum = rnd_x;
		endcase
	end

	// band output from the held band value
	always_comb begin
		y_r   = YR_BITS'(y_q) + OUT_HALF;
		o_pre = y_r[YR_BITS-1:STATE_FRAC_BITS];
		o_top = o_pre[OUT_PRE_BITS-1:SAMPLE_BITS-1];
		if ((&o_top) || !(|o_top)) begin
			band      = o_pre[SAMPLE_BITS-1:0];
			band_clip = 1'b0;
		end else begin
			band      = o_pre[OUT_PRE_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
				{1'b0, {(SAMPLE_BITS-1){1'b1}}};
			band_clip = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_on_q    <= 1'b0;
			iss_sec_q   <= 1'b0;
			iss_op_q    <= OP_FF0;
			mvld_s1     <= 1'b0;
			msec_s1     <= 1'b0;
			mop_s1      <= OP_FF0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++)
				coef_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				st_a_q[i] <= '0;
				st_b_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				iss_on_q  <= 1'b1;
				iss_sec_q <= 1'b0;
				iss_op_q  <= OP_FF0;
			end else if (iss_on_q) begin
				if (iss_op_q == OP_FB2_HI) begin
					iss_op_q <= OP_FF0;
					if (iss_sec_q)
						iss_on_q <= 1'b0;
					else
						iss_sec_q <= 1'b1;
				end else begin
					iss_op_q <= op_t'(iss_op_q + 3'd1);
				end
			end
			mvld_s1 <= iss_on_q;
			msec_s1 <= iss_sec_q;
			mop_s1  <= iss_op_q;

			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				coef_q[cfg_index] <= cfg_data;
				for (int i = 0; i < 2; i++) begin
					st_a_q[i] <= '0;
					st_b_q[i] <= '0;
				end
			end else if (mvld_s1) begin
				if (mop_s1 == OP_FB1_HI)
					st_a_q[msec_s1] <= sat_state(sum);
				if (mop_s1 == OP_FB2_HI)
					st_b_q[msec_s1] <= sat_state(sum);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_in;
			clip_q <= 1'b0;
		end
		prod_s1 <= mul_p;
		if (mvld_s1) begin
			case (mop_s1)
				OP_FF0: y_q <= sat_inner(sum);
				OP_FF1: begin
					ta_q <= sum;
					if (msec_s1)
						hi_q <= band;
					else
						lo_q <= band;
					clip_q <= clip_q | band_clip;
				end
				OP_FF2:               tb_q  <= sum;
				OP_FB1_LO, OP_FB2_LO: acc_q <= full;
				default: ;
			endcase
		end
		if (finish) begin
			low_band_q  <= lo_q;
			high_band_q <= hi_q;
			clipped_q   <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign low_band  = low_band_q;
	assign high_band = high_band_q;
	assign clipped   = clipped_q;

endmodule
